// ===== rtl/obbt_pkg.sv =====
// obbt_pkg: shared types and constants of the 2-D oriented-box overlap test.
// Used by obbt_mul, obbt_seq and obb_overlap_test_2d. No dependencies.
`timescale 1ns / 1ps

package obbt_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam int STEP_W = 4;
    localparam int AXIS_W = 2;

    // sequencer steps of one axis check; named by the multiply issued in that step
    localparam logic [STEP_W-1:0] ST_E0X  = 4'd0;  // n.x * e0.x
    localparam logic [STEP_W-1:0] ST_E0Y  = 4'd1;  // n.y * e0.y
    localparam logic [STEP_W-1:0] ST_E1X  = 4'd2;  // n.x * e1.x
    localparam logic [STEP_W-1:0] ST_E1Y  = 4'd3;  // n.y * e1.y
    localparam logic [STEP_W-1:0] ST_DX   = 4'd4;  // dx * n.x
    localparam logic [STEP_W-1:0] ST_DY   = 4'd5;  // dy * n.y
    localparam logic [STEP_W-1:0] ST_LEN0 = 4'd6;  // |n.e0| * len0
    localparam logic [STEP_W-1:0] ST_LEN1 = 4'd7;  // |n.e1| * len1
    localparam logic [STEP_W-1:0] ST_SUM  = 4'd8;  // last extent add
    localparam logic [STEP_W-1:0] ST_CMP  = 4'd9;  // distance vs extent
    localparam logic [STEP_W-1:0] STEP_LAST = ST_CMP;

    // axis under test
    localparam logic [AXIS_W-1:0] AX_A0 = 2'd0;
    localparam logic [AXIS_W-1:0] AX_A1 = 2'd1;
    localparam logic [AXIS_W-1:0] AX_B0 = 2'd2;
    localparam logic [AXIS_W-1:0] AX_B1 = 2'd3;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AX_B1;

    // input selector
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // sequencer to datapath control
    typedef struct packed {
        logic              busy;
        logic              done;   // final compare, result is issued this cycle
        logic [AXIS_W-1:0] axis;
        logic [STEP_W-1:0] step;
    } t_ctrl;

endpackage

// ===== rtl/obbt_mul.sv =====
// obbt_mul: shared signed multiplier with registered product.
// Depends on obbt_pkg.
`timescale 1ns / 1ps

module obbt_mul (
    input  logic                                 i_clk,
    input  logic signed [obbt_pkg::MUL_W-1:0]    i_a,
    input  logic signed [obbt_pkg::MUL_W-1:0]    i_b,
    output logic signed [obbt_pkg::PROD_W-1:0]   o_prod
);
    import obbt_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/obbt_seq.sv =====
// obbt_seq: step and axis sequencer for the overlap test.
// Depends on obbt_pkg (t_ctrl, step and axis codes).
`timescale 1ns / 1ps

module obbt_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_hold,    // result slot still occupied
    output obbt_pkg::t_ctrl  o_ctrl
);
    import obbt_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [AXIS_W-1:0] r_axis;
    logic              w_at_end;

    assign w_at_end = (r_step == STEP_LAST) && (r_axis == AXIS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_E0X;
            r_axis  <= AX_A0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_step <= ST_E0X;
                    r_axis <= AX_A0;
                    if (i_start) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == STEP_LAST) begin
                        if (r_axis == AXIS_LAST) begin
                            if (!i_hold) begin
                                r_state <= S_IDLE;
                                r_step  <= ST_E0X;
                                r_axis  <= AX_A0;
                            end
                        end else begin
                            r_step <= ST_E0X;
                            r_axis <= r_axis + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ctrl.busy = (r_state == S_RUN);
    assign o_ctrl.done = (r_state == S_RUN) && w_at_end && !i_hold;
    assign o_ctrl.axis = r_axis;
    assign o_ctrl.step = r_step;

endmodule

// ===== rtl/obb_overlap_test_2d.sv =====
// obb_overlap_test_2d: top level of the 2-D oriented-box separating-axis test.
// Depends on obbt_pkg, obbt_mul and obbt_seq.
`timescale 1ns / 1ps

// A load beat (tuser = 0) stores reference box A and returns nothing.
// A test beat (tuser = 1) checks box B against A on A's two axes and B's two axes
// and returns one beat with the overlap flag (1 = overlap, touching counts as
// overlap). All math is exact: centers and half lengths Q16.16, directions Q1.14,
// no rounding or saturation. A test runs through one shared 33x33 signed
// multiplier under a step sequencer: per axis 8 multiplies, one extent add and
// one compare. The input is not ready while a test runs. The result sits in an
// output register, so the next item is taken while it waits; a test finishing
// into an untaken result holds on its last step. Reset is synchronous, active
// low, and clears box A to all zeros.

module obb_overlap_test_2d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata, lowest bit up: center_x[31:0], center_y[63:32], axis0_x[79:64],
    // axis0_y[95:80], axis1_x[111:96], axis1_y[127:112], half_len0[158:128],
    // half_len1[189:159], zero pad [191:190]
    input  logic [191:0] i_s_tdata,
    // tuser: func[0]
    input  logic [0:0]   i_s_tuser,
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata, lowest bit up: overlap[0], zero pad [7:1]
    output logic [7:0]   o_m_tdata
);
    import obbt_pkg::*;

    // ---- input unpack
    logic signed [31:0] w_cx, w_cy;
    logic signed [15:0] w_0x, w_0y, w_1x, w_1y;
    logic        [30:0] w_l0, w_l1;
    logic               w_func;

    assign w_cx   = i_s_tdata[31:0];
    assign w_cy   = i_s_tdata[63:32];
    assign w_0x   = i_s_tdata[79:64];
    assign w_0y   = i_s_tdata[95:80];
    assign w_1x   = i_s_tdata[111:96];
    assign w_1y   = i_s_tdata[127:112];
    assign w_l0   = i_s_tdata[158:128];
    assign w_l1   = i_s_tdata[189:159];
    assign w_func = i_s_tuser[0];

    // ---- handshake and control
    t_ctrl w_ctrl;
    logic  w_s_acc, w_start, w_hold;
    logic  r_m_tvalid, r_overlap;

    assign o_s_tready = !w_ctrl.busy;
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_start    = w_s_acc && (w_func == FUNC_TEST);
    assign w_hold     = r_m_tvalid && !i_m_tready;

    obbt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_hold  (w_hold),
        .o_ctrl  (w_ctrl)
    );

    // ---- reference box A (reset to zero)
    logic signed [31:0] r_acx, r_acy;
    logic signed [15:0] r_a0x, r_a0y, r_a1x, r_a1y;
    logic        [30:0] r_la0, r_la1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acx <= '0;
            r_acy <= '0;
            r_a0x <= '0;
            r_a0y <= '0;
            r_a1x <= '0;
            r_a1y <= '0;
            r_la0 <= '0;
            r_la1 <= '0;
        end else if (w_s_acc && (w_func == FUNC_LOAD)) begin
            r_acx <= w_cx;
            r_acy <= w_cy;
            r_a0x <= w_0x;
            r_a0y <= w_0y;
            r_a1x <= w_1x;
            r_a1y <= w_1y;
            r_la0 <= w_l0;
            r_la1 <= w_l1;
        end
    end

    // ---- box B and center difference, captured on a test beat
    logic signed [15:0] r_b0x, r_b0y, r_b1x, r_b1y;
    logic        [30:0] r_lb0, r_lb1;
    logic signed [32:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_b0x <= w_0x;
            r_b0y <= w_0y;
            r_b1x <= w_1x;
            r_b1y <= w_1y;
            r_lb0 <= w_l0;
            r_lb1 <= w_l1;
            r_dx  <= 33'(r_acx) - 33'(w_cx);
            r_dy  <= 33'(r_acy) - 33'(w_cy);
        end
    end

    // ---- per-axis selection: axis n, its owner's half length, the other box
    logic signed [15:0] w_nx, w_ny, w_e0x, w_e0y, w_e1x, w_e1y;
    logic        [30:0] w_own, w_len0, w_len1;

    always_comb begin
        w_nx   = r_a0x;
        w_ny   = r_a0y;
        w_own  = r_la0;
        w_e0x  = r_b0x;
        w_e0y  = r_b0y;
        w_e1x  = r_b1x;
        w_e1y  = r_b1y;
        w_len0 = r_lb0;
        w_len1 = r_lb1;
        case (w_ctrl.axis)
            AX_A0: begin
                w_nx  = r_a0x;
                w_ny  = r_a0y;
                w_own = r_la0;
            end
            AX_A1: begin
                w_nx  = r_a1x;
                w_ny  = r_a1y;
                w_own = r_la1;
            end
            AX_B0, AX_B1: begin
                w_nx   = (w_ctrl.axis == AX_B0) ? r_b0x : r_b1x;
                w_ny   = (w_ctrl.axis == AX_B0) ? r_b0y : r_b1y;
                w_own  = (w_ctrl.axis == AX_B0) ? r_lb0 : r_lb1;
                w_e0x  = r_a0x;
                w_e0y  = r_a0y;
                w_e1x  = r_a1x;
                w_e1y  = r_a1y;
                w_len0 = r_la0;
                w_len1 = r_la1;
            end
            default: begin
                w_nx = '0;
                w_ny = '0;
            end
        endcase
    end

    // ---- multiplier operand select
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [32:0]       r_t0, r_t1;   // |n.e0|, |n.e1|

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (w_ctrl.step)
            ST_E0X:  begin w_ma = MUL_W'(w_nx); w_mb = MUL_W'(w_e0x); end
            ST_E0Y:  begin w_ma = MUL_W'(w_ny); w_mb = MUL_W'(w_e0y); end
            ST_E1X:  begin w_ma = MUL_W'(w_nx); w_mb = MUL_W'(w_e1x); end
            ST_E1Y:  begin w_ma = MUL_W'(w_ny); w_mb = MUL_W'(w_e1y); end
            ST_DX:   begin w_ma = r_dx;         w_mb = MUL_W'(w_nx);  end
            ST_DY:   begin w_ma = r_dy;         w_mb = MUL_W'(w_ny);  end
            ST_LEN0: begin w_ma = r_t0; w_mb = MUL_W'({2'b00, w_len0}); end
            ST_LEN1: begin w_ma = r_t1; w_mb = MUL_W'({2'b00, w_len1}); end
            default: begin w_ma = '0;           w_mb = '0;            end
        endcase
    end

    obbt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // ---- accumulation: each step folds in the product issued one step earlier
    logic signed [32:0] w_tsum;
    logic signed [49:0] r_acc, w_dsum;
    logic        [48:0] r_dist;       // |d.n| at Q.30
    logic        [63:0] r_ext;        // extent sum at Q.44
    logic               r_apart, w_sep;

    assign w_tsum = (w_ctrl.step == ST_E1X) ? (r_t0 + w_prod[32:0])
                                            : (r_t1 + w_prod[32:0]);
    assign w_dsum = r_acc + w_prod[49:0];
    assign w_sep  = {1'b0, r_dist, 14'b0} > r_ext;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.busy) begin
            case (w_ctrl.step)
                ST_E0Y:  r_t0 <= w_prod[32:0];
                ST_E1X:  r_t0 <= w_tsum[32] ? -w_tsum : w_tsum;
                ST_E1Y:  r_t1 <= w_prod[32:0];
                ST_DX:   r_t1 <= w_tsum[32] ? -w_tsum : w_tsum;
                ST_DY:   r_acc <= w_prod[49:0];
                ST_LEN0: r_dist <= w_dsum[49] ? 49'(-w_dsum) : w_dsum[48:0];
                ST_LEN1: r_ext <= {5'b0, w_own, 28'b0} + w_prod[63:0];
                ST_SUM:  r_ext <= r_ext + w_prod[63:0];
                default: ;
            endcase
        end
    end

    // apart flag: OR over the four axes, cleared at test start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apart <= 1'b0;
        end else if (w_start) begin
            r_apart <= 1'b0;
        end else if (w_ctrl.busy && (w_ctrl.step == ST_CMP)) begin
            r_apart <= r_apart | w_sep;
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
            r_overlap  <= 1'b0;
        end else if (w_ctrl.done) begin
            r_m_tvalid <= 1'b1;
            r_overlap  <= !(r_apart | w_sep);
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {7'b0, r_overlap};

    // ---- assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.busy |-> !o_s_tready)
        else $error("input taken while a test runs");

    a_result_from_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_ctrl.done))
        else $error("result beat without a finished test");

    a_done_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.done |=> (o_m_tvalid && !w_ctrl.busy))
        else $error("finished test did not present its result");

    a_hold_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.busy && w_ctrl.step == STEP_LAST && w_ctrl.axis == AXIS_LAST && w_hold)
        |=> (w_ctrl.busy && $stable(r_overlap)))
        else $error("test ended into an occupied result slot");

endmodule

// ===== sim/tb_obb_overlap_test_2d.sv =====
// tb_obb_overlap_test_2d: self-checking testbench of the 2-D oriented-box overlap test.
// Depends on obbt_pkg and obb_overlap_test_2d; a queue-fed driver, a monitor and an
// in-bench predictor of the separating-axis test.
`timescale 1ns / 1ps

module tb_obb_overlap_test_2d;

    import obbt_pkg::*;

    // Q16.16 one and Q1.14 unit length
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [15:0] DIR_UNIT   = 16'sd16384;
    localparam logic [15:0] DIR_45     = 16'sd11585;
    localparam int          ITEMS_PER_PHASE = 258;
    localparam int          DRAIN_CYCLES    = 100;

    // one input beat, unpacked
    typedef struct {
        logic               func;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] a0x;
        logic signed [15:0] a0y;
        logic signed [15:0] a1x;
        logic signed [15:0] a1y;
        logic        [30:0] hl0;
        logic        [30:0] hl1;
    } t_box;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // tdata, lowest bit up: center_x, center_y, axis0_x, axis0_y, axis1_x, axis1_y,
    // half_len0, half_len1, zero pad
    logic [191:0] i_s_tdata  = '0;
    // tuser: func
    logic [0:0]   i_s_tuser  = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // tdata, lowest bit up: overlap, zero pad
    logic [7:0]   o_m_tdata;

    obb_overlap_test_2d i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_box pending[$];           // beats waiting for the driver
    bit   overlap_expected[$];  // predicted overlap flags, oldest first
    t_box box_a;                // predictor copy of stored box A
    t_box beat_on_bus;          // beat currently offered on the slave side
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   err_count       = 0;
    int   result_count    = 0;
    bit   want_overlap;

    // last box A handed to the driver, so shaped tests land near it
    logic signed [31:0] gen_ax = '0;
    logic signed [31:0] gen_ay = '0;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic bit [63:0] abs_wide(input longint s);
        return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    // Axis n owned by a box with half length own_len; e0/e1 are the other box's axes.
    // Everything is Q.44 here: distance (Q.30 << 14), own extent (Q16.16 << 28) and
    // the projected other extents (Q.28 * Q16.16). Strictly greater means apart.
    function automatic bit axis_separates(
        input longint nx, input longint ny, input bit [63:0] own_len,
        input longint e0x, input longint e0y, input bit [63:0] len0,
        input longint e1x, input longint e1y, input bit [63:0] len1,
        input longint dx, input longint dy);
        bit [63:0] proj_dist;
        bit [63:0] ext;
        proj_dist = abs_wide(dx * nx + dy * ny) << 14;
        ext  = (own_len << 28)
             + abs_wide(nx * e0x + ny * e0y) * len0
             + abs_wide(nx * e1x + ny * e1y) * len1;
        return proj_dist > ext;
    endfunction

    // A's two axes first, then B's two; overlap unless one of them separates
    function automatic bit predict_overlap(input t_box a, input t_box b);
        longint dx;
        longint dy;
        bit     apart;
        dx = longint'(a.cx) - longint'(b.cx);
        dy = longint'(a.cy) - longint'(b.cy);
        apart = axis_separates(a.a0x, a.a0y, a.hl0, b.a0x, b.a0y, b.hl0,
                               b.a1x, b.a1y, b.hl1, dx, dy)
             || axis_separates(a.a1x, a.a1y, a.hl1, b.a0x, b.a0y, b.hl0,
                               b.a1x, b.a1y, b.hl1, dx, dy)
             || axis_separates(b.a0x, b.a0y, b.hl0, a.a0x, a.a0y, a.hl0,
                               a.a1x, a.a1y, a.hl1, dx, dy)
             || axis_separates(b.a1x, b.a1y, b.hl1, a.a0x, a.a0y, a.hl0,
                               a.a1x, a.a1y, a.hl1, dx, dy);
        return !apart;
    endfunction

    task automatic push_box(input logic func, input logic [31:0] cx, input logic [31:0] cy,
                            input logic [15:0] a0x, input logic [15:0] a0y,
                            input logic [15:0] a1x, input logic [15:0] a1y,
                            input logic [30:0] hl0, input logic [30:0] hl1);
        t_box b;
        b.func = func;
        b.cx   = cx;
        b.cy   = cy;
        b.a0x  = a0x;
        b.a0y  = a0y;
        b.a1x  = a1x;
        b.a1y  = a1y;
        b.hl0  = hl0;
        b.hl1  = hl1;
        if (func == FUNC_LOAD) begin
            gen_ax = cx;
            gen_ay = cy;
        end
        pending.push_back(b);
    endtask

    // Realistic box: near-unit orthogonal axes, size and offset on a random scale.
    // Loads pick a fresh center, tests sit around the last loaded center so both
    // outcomes show up often.
    task automatic push_shaped(input logic func);
        int sc;
        int ax;
        int ay;
        int bx;
        int by;
        sc = $urandom_range(10, 24);
        ax = int'($urandom_range(0, 32768)) - 16384;
        ay = $rtoi($sqrt(268435456.0 - real'(ax) * real'(ax)));
        if ($urandom_range(0, 1) == 1)
            ay = -ay;
        if (func == FUNC_LOAD) begin
            bx = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            by = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        end else begin
            bx = gen_ax + int'($urandom_range(0, 6 << sc)) - (3 << sc);
            by = gen_ay + int'($urandom_range(0, 6 << sc)) - (3 << sc);
        end
        if ($urandom_range(0, 1) == 1)
            push_box(func, bx, by, 16'(ax), 16'(ay), 16'(-ay), 16'(ax),
                     31'($urandom_range(1, 1 << sc)), 31'($urandom_range(1, 1 << sc)));
        else
            push_box(func, bx, by, 16'(ax), 16'(ay), 16'(ay), 16'(-ax),
                     31'($urandom_range(1, 1 << sc)), 31'($urandom_range(1, 1 << sc)));
    endtask

    // every field drawn over its full width
    task automatic push_noise(input logic func);
        push_box(func, $urandom, $urandom, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 31'($urandom), 31'($urandom));
    endtask

    task automatic push_random_phase();
        int r;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                push_shaped(FUNC_LOAD);
            else if (r < 16)
                push_noise(FUNC_LOAD);
            else if (r < 84)
                push_shaped(FUNC_TEST);
            else
                push_noise(FUNC_TEST);
        end
    endtask

    // Driver: offers the next pending beat once the previous one is taken, with
    // random idle cycles. The predictor is updated on each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            box_a = '{default: '0};
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (beat_on_bus.func == FUNC_LOAD)
                    box_a = beat_on_bus;
                else
                    overlap_expected.push_back(predict_overlap(box_a, beat_on_bus));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    beat_on_bus = pending.pop_front();
                    i_s_tdata  <= {2'b00, beat_on_bus.hl1, beat_on_bus.hl0,
                                   beat_on_bus.a1y, beat_on_bus.a1x,
                                   beat_on_bus.a0y, beat_on_bus.a0x,
                                   beat_on_bus.cy, beat_on_bus.cx};
                    i_s_tuser  <= beat_on_bus.func;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken result beat against the oldest prediction,
    // and stalls the master side at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                result_count++;
                if (overlap_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d has no pending test", result_count));
                end else begin
                    want_overlap = overlap_expected.pop_front();
                    if (o_m_tdata[0] !== want_overlap)
                        report_mismatch($sformatf("result %0d overlap %b, expected %b",
                                                  result_count, o_m_tdata[0], want_overlap));
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // -- directed part, no idling --
        // tests before any load run against the all-zero box A
        push_box(FUNC_TEST, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 16'h8000,
                 16'h4000, 16'hc000, 31'h7fff_ffff, 31'h0);
        push_box(FUNC_TEST, '0, '0, '0, '0, '0, '0, '0, '0);
        // axis-aligned unit box A at the origin
        push_box(FUNC_LOAD, '0, '0, DIR_UNIT, '0, '0, DIR_UNIT, Q_ONE, Q_ONE);
        // touching along x counts as overlap, one LSB further is apart
        push_box(FUNC_TEST, 2 * Q_ONE, '0, DIR_UNIT, '0, '0, DIR_UNIT, Q_ONE, Q_ONE);
        push_box(FUNC_TEST, 2 * Q_ONE + 1, '0, DIR_UNIT, '0, '0, DIR_UNIT, Q_ONE, Q_ONE);
        // same along y, negative side
        push_box(FUNC_TEST, '0, -2 * Q_ONE, DIR_UNIT, '0, '0, DIR_UNIT, Q_ONE, Q_ONE);
        push_box(FUNC_TEST, '0, -2 * Q_ONE - 1, DIR_UNIT, '0, '0, DIR_UNIT, Q_ONE, Q_ONE);
        // B rotated by 45 degrees near the corner
        push_box(FUNC_TEST, 2 * Q_ONE, 2 * Q_ONE, DIR_45, DIR_45, -DIR_45, DIR_45,
                 Q_ONE, Q_ONE);
        // zero-size B at A's center
        push_box(FUNC_TEST, '0, '0, '0, '0, '0, '0, '0, '0);
        // extremes: largest centers, -32768 directions, largest half lengths
        push_box(FUNC_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 31'h7fff_ffff, 31'h7fff_ffff);
        push_box(FUNC_TEST, 32'h8000_0000, 32'h8000_0000, 16'h7fff, 16'h7fff,
                 16'h7fff, 16'h7fff, 31'h7fff_ffff, 31'h7fff_ffff);
        push_box(FUNC_TEST, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0, '0, '0);
        push_box(FUNC_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, '0, '0);
        // degenerate A at the most negative corner, B at the opposite one
        push_box(FUNC_LOAD, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0, '0, '0);
        push_box(FUNC_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 31'h7fff_ffff, 31'h7fff_ffff);
        push_box(FUNC_TEST, 32'h7fff_ffff, 32'h7fff_ffff, DIR_UNIT, '0, '0, DIR_UNIT,
                 '0, '0);
        // A turned by 90 degrees, 3 x 1 half lengths, off the origin
        push_box(FUNC_LOAD, 100 * Q_ONE, -100 * Q_ONE, '0, DIR_UNIT, -DIR_UNIT, '0,
                 3 * Q_ONE, Q_ONE);
        push_box(FUNC_TEST, 104 * Q_ONE, -100 * Q_ONE, DIR_UNIT, '0, '0, DIR_UNIT,
                 Q_ONE, Q_ONE);
        push_box(FUNC_TEST, 101 * Q_ONE, -97 * Q_ONE, DIR_UNIT, '0, '0, DIR_UNIT,
                 Q_ONE, Q_ONE);
        push_box(FUNC_TEST, 102 * Q_ONE, -100 * Q_ONE, DIR_UNIT, '0, '0, DIR_UNIT,
                 Q_ONE, Q_ONE);

        // -- random part, four idling phases --
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            push_random_phase();
            while (pending.size() != 0)
                @(posedge i_clk);
            @(negedge i_clk);
        end

        // drain: last beat taken, every result back, then a further wait of DRAIN_CYCLES
        while (pending.size() != 0 || i_s_tvalid || overlap_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (overlap_expected.size() != 0)
            report_mismatch($sformatf("%0d predicted results never came",
                                      overlap_expected.size()));

        if (err_count == 0)
            $display("PASS obb_overlap_test_2d");
        else
            $display("FAIL obb_overlap_test_2d");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL obb_overlap_test_2d");
        $finish;
    end

endmodule
